/* src/fwsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front-wall stop correction package
// Shared field widths, transfer structs, action codes and settings register
// indexes for the correction core and its datapath units.
// ----------------------------------------------------------------------------
package fwsc_pkg;

   // Field widths fixed by the command and result formats.
   localparam int DIST_W    = 13;
   localparam int STOP_W    = 10;
   localparam int SLOW_W    = 12;
   localparam int CPM_W     = 16;
   localparam int ALPHA_W   = 9;
   localparam int RPM_W     = 10;
   localparam int POS_W     = 32;
   localparam int LO_OFF_W  = 18;
   localparam int HI_OFF_W  = 17;

   // Speed bound actions carried in the result.
   localparam logic [1:0] ACT_KEEP = 2'd0;
   localparam logic [1:0] ACT_FULL = 2'd1;
   localparam logic [1:0] ACT_CAP  = 2'd2;

   // Settings register indexes on the write port.
   localparam logic [2:0] REG_MAX_RANGE = 3'd0;
   localparam logic [2:0] REG_STOP_DIST = 3'd1;
   localparam logic [2:0] REG_DEADBAND  = 3'd2;
   localparam logic [2:0] REG_SLOW_ZONE = 3'd3;
   localparam logic [2:0] REG_CPM       = 3'd4;
   localparam logic [2:0] REG_CELL_SIZE = 3'd5;
   localparam logic [2:0] REG_ALPHA     = 3'd6;
   localparam logic [2:0] REG_MIN_RPM   = 3'd7;

   typedef struct packed {
      logic [DIST_W-1:0]       front_filtered_mm;
      logic [DIST_W-1:0]       front_raw_mm;
      logic signed [POS_W-1:0] position_counts;
      logic signed [POS_W-1:0] current_target;
      logic signed [POS_W-1:0] base_target;
   } req_type;

   typedef struct packed {
      logic [1:0]              bound_action;
      logic [RPM_W-1:0]        upper_bound_rpm;
      logic                    target_update;
      logic signed [POS_W-1:0] new_target;
   } rsp_type;

   // Settings that the target path needs, already scaled to counts.
   typedef struct packed {
      logic [CPM_W-1:0]    counts_per_mm;
      logic [LO_OFF_W-1:0] lo_offset;
      logic [HI_OFF_W-1:0] hi_offset;
      logic [ALPHA_W-1:0]  blend_alpha;
   } tgt_cfg_type;

endpackage

/* src/fwsc_target_path.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front-wall stop correction target path
// Seven-stage pipeline: ideal travel to counts, clamp around the base target,
// blend into the current target and saturate to 32 bits.
// ----------------------------------------------------------------------------
module fwsc_target_path (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic [fwsc_pkg::DIST_W-1:0]           in_ideal,
   input  logic signed [fwsc_pkg::POS_W-1:0]     in_pos,
   input  logic signed [fwsc_pkg::POS_W-1:0]     in_cur,
   input  logic signed [fwsc_pkg::POS_W-1:0]     in_base,
   input  fwsc_pkg::tgt_cfg_type                 cfg,
   output logic                                  out_valid,
   output logic signed [fwsc_pkg::POS_W-1:0]     out_target
);
   import fwsc_pkg::*;

   localparam int STAGES = 7;

   logic [STAGES-1:0] v_ff;

   logic [DIST_W+CPM_W-1:0]  prod1_ff;
   logic signed [POS_W-1:0]  pos1_ff, cur1_ff, base1_ff;
   logic signed [33:0]       cand2_ff, lo2_ff, hi2_ff;
   logic signed [33:0]       cand2_in, lo2_in, hi2_in;
   logic signed [POS_W-1:0]  cur2_ff, cur3_ff, cur4_ff, cur5_ff;
   logic signed [33:0]       clamp3;
   logic signed [34:0]       diff3_ff, diff3_in;
   logic signed [ALPHA_W:0]  alpha_s;
   logic signed [44:0]       mp4_ff, mp4_in;
   logic signed [44:0]       mp_adj;
   logic signed [36:0]       q5_ff;
   logic signed [37:0]       sum6_ff, sum6_in;
   logic signed [POS_W-1:0]  tgt7_ff, tgt7_in;

   // Valid bits travel alongside the data stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[STAGES-2:0], in_valid};
      end
   end

   // Stage 2: candidate position and the clamp window around the base target.
   always_comb begin
      cand2_in = $signed({{2{pos1_ff[POS_W-1]}}, pos1_ff})
               + $signed({13'b0, prod1_ff[DIST_W+CPM_W-1:8]});
      lo2_in   = $signed({{2{base1_ff[POS_W-1]}}, base1_ff})
               - $signed({16'b0, cfg.lo_offset});
      hi2_in   = $signed({{2{base1_ff[POS_W-1]}}, base1_ff})
               + $signed({17'b0, cfg.hi_offset});
   end

   // Stage 3: clamp the candidate and take its distance from the current target.
   always_comb begin
      if (cand2_ff < lo2_ff) begin
         clamp3 = lo2_ff;
      end else if (cand2_ff > hi2_ff) begin
         clamp3 = hi2_ff;
      end else begin
         clamp3 = cand2_ff;
      end
      diff3_in = $signed({clamp3[33], clamp3})
               - $signed({{3{cur2_ff[POS_W-1]}}, cur2_ff});
   end

   // Stage 4: weight the distance by the blend factor.
   always_comb begin
      alpha_s = $signed({1'b0, cfg.blend_alpha});
      mp4_in  = alpha_s * diff3_ff;
   end

   // Stage 5 divides by 256 toward zero; stage 6 adds the current target back.
   always_comb begin
      mp_adj  = mp4_ff + (mp4_ff[44] ? 45'sd255 : 45'sd0);
      sum6_in = $signed({{6{cur5_ff[POS_W-1]}}, cur5_ff})
              + $signed({q5_ff[36], q5_ff});
   end

   // Stage 7: saturate to the 32-bit target range.
   always_comb begin
      if (sum6_ff[37:31] == {7{sum6_ff[31]}}) begin
         tgt7_in = sum6_ff[31:0];
      end else if (sum6_ff[37]) begin
         tgt7_in = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         tgt7_in = {1'b0, {(POS_W-1){1'b1}}};
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      prod1_ff <= in_ideal * cfg.counts_per_mm;
      pos1_ff  <= in_pos;
      cur1_ff  <= in_cur;
      base1_ff <= in_base;
      cand2_ff <= cand2_in;
      lo2_ff   <= lo2_in;
      hi2_ff   <= hi2_in;
      cur2_ff  <= cur1_ff;
      diff3_ff <= diff3_in;
      cur3_ff  <= cur2_ff;
      mp4_ff   <= mp4_in;
      cur4_ff  <= cur3_ff;
      q5_ff    <= mp_adj[44:8];
      cur5_ff  <= cur4_ff;
      sum6_ff  <= sum6_in;
      tgt7_ff  <= tgt7_in;
   end

   assign out_valid  = v_ff[STAGES-1];
   assign out_target = tgt7_ff;

endmodule

/* src/fwsc_cap_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front-wall stop correction speed cap ramp
// Pipelined restoring divider that works out the ramp between the minimum
// approach speed and full speed over the slow zone.
// ----------------------------------------------------------------------------
module fwsc_cap_div #(
   parameter int MAX_RPM = 200
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [fwsc_pkg::SLOW_W-1:0]     in_clr,
   input  logic [fwsc_pkg::RPM_W-1:0]      min_rpm,
   input  logic [fwsc_pkg::SLOW_W-1:0]     slow_zone,
   output logic                            out_valid,
   output logic [fwsc_pkg::RPM_W-1:0]      out_cap
);
   import fwsc_pkg::*;

   localparam int QBITS = RPM_W;
   localparam int STEP  = 2;
   localparam int NSTG  = QBITS / STEP;
   localparam int REM_W = SLOW_W + RPM_W;
   localparam logic [RPM_W-1:0] MaxRpm = RPM_W'(MAX_RPM);

   logic signed [RPM_W+1:0] span;
   logic [RPM_W-1:0]        span_mag;

   logic [REM_W-1:0]        rem_ff [0:NSTG];
   logic [QBITS-1:0]        quo_ff [0:NSTG];
   logic                    neg_ff [0:NSTG];
   logic                    v_ff   [0:NSTG];
   logic [REM_W-1:0]        rem_in [1:NSTG];
   logic [QBITS-1:0]        quo_in [1:NSTG];

   logic signed [RPM_W:0]   q_signed;
   logic signed [RPM_W:0]   cap_in;
   logic [RPM_W-1:0]        cap_ff;
   logic                    out_v_ff;

   // Signed speed span of the ramp; the divider works on its magnitude.
   always_comb begin
      span     = $signed({2'b0, MaxRpm}) - $signed({2'b0, min_rpm});
      span_mag = span[RPM_W+1] ? RPM_W'(-span) : span[RPM_W-1:0];
   end

   // Front stage: numerator of the ramp.
   always_ff @(posedge clock) begin
      rem_ff[0] <= in_clr * span_mag;
      quo_ff[0] <= '0;
      neg_ff[0] <= span[RPM_W+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
   end

   // Two quotient bits per stage, most significant first.
   for (genvar s = 0; s < NSTG; s++) begin : g_div
      always_comb begin
         logic [REM_W-1:0] r;
         logic [QBITS-1:0] q;
         logic [REM_W-1:0] sh;
         r = rem_ff[s];
         q = quo_ff[s];
         for (int j = 0; j < STEP; j++) begin
            sh = {{(REM_W-SLOW_W){1'b0}}, slow_zone} << (QBITS - 1 - s * STEP - j);
            if (r >= sh) begin
               r = r - sh;
               q = {q[QBITS-2:0], 1'b1};
            end else begin
               q = {q[QBITS-2:0], 1'b0};
            end
         end
         rem_in[s+1] = r;
         quo_in[s+1] = q;
      end

      always_ff @(posedge clock) begin
         rem_ff[s+1] <= rem_in[s+1];
         quo_ff[s+1] <= quo_in[s+1];
         neg_ff[s+1] <= neg_ff[s];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else begin
            v_ff[s+1] <= v_ff[s];
         end
      end
   end

   // Last stage: apply the sign and add the minimum speed.
   always_comb begin
      q_signed = neg_ff[NSTG] ? -$signed({1'b0, quo_ff[NSTG]})
                              : $signed({1'b0, quo_ff[NSTG]});
      cap_in   = $signed({1'b0, min_rpm}) + q_signed;
   end

   always_ff @(posedge clock) begin
      cap_ff <= cap_in[RPM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= v_ff[NSTG];
      end
   end

   assign out_valid = out_v_ff;
   assign out_cap   = cap_ff;

endmodule

/* src/front_wall_stop_correction_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front-wall stop correction core
// Picks the front distance, decides the forward speed bound and pulls the
// position target toward the point where the wall reads the stop distance.
// ----------------------------------------------------------------------------
// Use:
//   A command is taken at a rising edge with start high and busy low. busy is
//   high only while reset is applied and for the cycle after it; otherwise a
//   new command may be given in every cycle.
//   Each command gives exactly one result. It is on rsp_data for one cycle,
//   marked by rsp_strobe, and results leave in command order. The receiver
//   cannot stall the core.
//   Throughput is one command per cycle. The latency is set by the seven
//   stages of the target blend and of the speed cap divider, which run side
//   by side behind two decode stages, plus the result register.
//   Settings are written through csr_wr_en, csr_index and csr_wdata, one register
//   per cycle; the user writes them only while no command is in flight (not enforced).
//   Reset loads the default settings and empties the pipeline; no result is
//   in flight afterwards.
// ----------------------------------------------------------------------------
module front_wall_stop_correction_core #(
   parameter int MAX_RPM = 200
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  fwsc_pkg::req_type     req_data,
   output logic                  rsp_strobe,
   output fwsc_pkg::rsp_type     rsp_data,
   input  logic                  csr_wr_en,
   input  logic [2:0]            csr_index,
   input  logic [15:0]           csr_wdata
);
   import fwsc_pkg::*;

   localparam int DLY     = 7;
   localparam int RSP_LAT = DLY + 3;
   localparam logic [RPM_W-1:0] MaxRpm = RPM_W'(MAX_RPM);

   typedef enum logic [1:0] {
      MODE_NONE   = 2'd0,
      MODE_FULL   = 2'd1,
      MODE_DEAD   = 2'd2,
      MODE_NORMAL = 2'd3
   } mode_type;

   // Settings registers.
   logic [DIST_W-1:0]  max_range_ff;
   logic [STOP_W-1:0]  stop_ff;
   logic [7:0]         deadband_ff;
   logic [SLOW_W-1:0]  slow_ff;
   logic [CPM_W-1:0]   cpm_ff;
   logic [9:0]         cell_ff;
   logic [ALPHA_W-1:0] alpha_ff;
   logic [RPM_W-1:0]   min_rpm_ff;

   // Settings scaled to counts.
   logic [25:0]          cellcpm_ff;
   logic [28:0]          win_lo_ff;
   logic [30:0]          win_hi_ff;
   logic [LO_OFF_W-1:0]  lo_off_ff;
   logic [HI_OFF_W-1:0]  hi_off_ff;
   logic [27:0]          three_p;
   tgt_cfg_type          tgt_cfg;

   logic    busy_ff;
   logic    accept;

   // Decode stages.
   logic                    s1_v_ff;
   req_type                 s1_req_ff;
   logic [DIST_W-1:0]       front;
   logic signed [DIST_W:0]  clr;
   logic [DIST_W-1:0]       ideal;
   logic signed [POS_W:0]   rem;

   logic                    s2_v_ff;
   logic                    s2_nofront_ff, s2_far_ff, s2_dead_ff, s2_le0_ff, s2_geslow_ff;
   logic signed [DIST_W:0]  s2_clr_ff;
   logic [DIST_W-1:0]       s2_ideal_ff;
   logic signed [POS_W:0]   s2_rem_ff;
   logic signed [POS_W-1:0] s2_pos_ff, s2_cur_ff, s2_base_ff;

   logic signed [44:0]      rem_x;
   logic                    outside;
   mode_type                mode_in;

   // Decision delay line, aligned with the blend and divider pipelines.
   mode_type                mode_ff   [0:DLY-1];
   logic                    le0_ff    [0:DLY-1];
   logic                    geslow_ff [0:DLY-1];
   logic                    mv_ff     [0:DLY-1];

   logic                    tgt_v;
   logic signed [POS_W-1:0] tgt_new;
   logic                    div_v;
   logic [RPM_W-1:0]        div_cap;

   rsp_type                 rsp_in;
   rsp_type                 rsp_ff;
   logic                    rsp_strobe_ff;
   logic [RPM_W-1:0]        cap_sel;

   assign accept = start && !busy_ff;

   // Command port is held off while reset is applied and for one cycle after.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   // Settings write port.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_range_ff <= 13'd250;
         stop_ff      <= 10'd35;
         deadband_ff  <= 8'd3;
         slow_ff      <= 12'd100;
         cpm_ff       <= 16'd256;
         cell_ff      <= 10'd180;
         alpha_ff     <= 9'd64;
         min_rpm_ff   <= 10'd40;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_MAX_RANGE: max_range_ff <= csr_wdata[DIST_W-1:0];
            REG_STOP_DIST: stop_ff      <= csr_wdata[STOP_W-1:0];
            REG_DEADBAND:  deadband_ff  <= csr_wdata[7:0];
            REG_SLOW_ZONE: slow_ff      <= csr_wdata[SLOW_W-1:0];
            REG_CPM:       cpm_ff       <= csr_wdata[CPM_W-1:0];
            REG_CELL_SIZE: cell_ff      <= csr_wdata[9:0];
            REG_ALPHA:     alpha_ff     <= csr_wdata[ALPHA_W-1:0];
            REG_MIN_RPM:   min_rpm_ff   <= csr_wdata[RPM_W-1:0];
            default: ;
         endcase
      end
   end

   // Cell pitch in counts and the window and clamp limits derived from it.
   assign three_p = {2'b0, cellcpm_ff} + {1'b0, cellcpm_ff, 1'b0};

   always_ff @(posedge clock) begin
      cellcpm_ff <= cell_ff * cpm_ff;
      win_lo_ff  <= ({3'b0, cellcpm_ff} << 2) + ({3'b0, cellcpm_ff} << 1);
      win_hi_ff  <= ({5'b0, cellcpm_ff} << 4) + ({5'b0, cellcpm_ff} << 2);
      lo_off_ff  <= three_p[27:10];
      hi_off_ff  <= cellcpm_ff[25:9];
   end

   always_comb begin
      tgt_cfg.counts_per_mm = cpm_ff;
      tgt_cfg.lo_offset     = lo_off_ff;
      tgt_cfg.hi_offset     = hi_off_ff;
      tgt_cfg.blend_alpha   = alpha_ff;
   end

   // Stage 1: capture the command.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_data;
      end
   end

   // Stage 2: choose the distance, clearance and remaining travel.
   always_comb begin
      if (s1_req_ff.front_raw_mm != '0 &&
          s1_req_ff.front_raw_mm < s1_req_ff.front_filtered_mm) begin
         front = s1_req_ff.front_raw_mm;
      end else begin
         front = s1_req_ff.front_filtered_mm;
      end
      clr   = $signed({1'b0, front}) - $signed({4'b0, stop_ff});
      ideal = clr[DIST_W] ? '0 : clr[DIST_W-1:0];
      rem   = $signed({s1_req_ff.base_target[POS_W-1], s1_req_ff.base_target})
            - $signed({s1_req_ff.position_counts[POS_W-1], s1_req_ff.position_counts});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_nofront_ff <= (front == '0);
      s2_far_ff     <= (front > max_range_ff);
      s2_dead_ff    <= (ideal < {5'b0, deadband_ff});
      s2_le0_ff     <= clr[DIST_W] || (clr == '0);
      s2_geslow_ff  <= !clr[DIST_W] && (clr[DIST_W-1:0] >= {1'b0, slow_ff});
      s2_clr_ff     <= clr;
      s2_ideal_ff   <= ideal;
      s2_rem_ff     <= rem;
      s2_pos_ff     <= s1_req_ff.position_counts;
      s2_cur_ff     <= s1_req_ff.current_target;
      s2_base_ff    <= s1_req_ff.base_target;
   end

   // Stage 3: travel window test in tenths of a cell, and the decision.
   always_comb begin
      rem_x   = ($signed({{12{s2_rem_ff[POS_W]}}, s2_rem_ff}) <<< 11)
              + ($signed({{12{s2_rem_ff[POS_W]}}, s2_rem_ff}) <<< 9);
      outside = (rem_x < -$signed({16'b0, win_lo_ff}))
             || (rem_x > $signed({14'b0, win_hi_ff}));
      if (s2_nofront_ff) begin
         mode_in = MODE_NONE;
      end else if (s2_far_ff || outside) begin
         mode_in = MODE_FULL;
      end else if (s2_dead_ff) begin
         mode_in = MODE_DEAD;
      end else begin
         mode_in = MODE_NORMAL;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff[0]   <= mode_in;
      le0_ff[0]    <= s2_le0_ff;
      geslow_ff[0] <= s2_geslow_ff;
      for (int k = 1; k < DLY; k++) begin
         mode_ff[k]   <= mode_ff[k-1];
         le0_ff[k]    <= le0_ff[k-1];
         geslow_ff[k] <= geslow_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DLY; k++) begin
            mv_ff[k] <= 1'b0;
         end
      end else begin
         mv_ff[0] <= s2_v_ff;
         for (int k = 1; k < DLY; k++) begin
            mv_ff[k] <= mv_ff[k-1];
         end
      end
   end

   // Target blend and speed cap ramp run side by side.
   fwsc_target_path u_target (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s2_v_ff),
      .in_ideal   (s2_ideal_ff),
      .in_pos     (s2_pos_ff),
      .in_cur     (s2_cur_ff),
      .in_base    (s2_base_ff),
      .cfg        (tgt_cfg),
      .out_valid  (tgt_v),
      .out_target (tgt_new)
   );

   fwsc_cap_div #(
      .MAX_RPM (MAX_RPM)
   ) u_cap_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_v_ff),
      .in_clr    (s2_clr_ff[SLOW_W-1:0]),
      .min_rpm   (min_rpm_ff),
      .slow_zone (slow_ff),
      .out_valid (div_v),
      .out_cap   (div_cap)
   );

   // Result assembly.
   always_comb begin
      if (le0_ff[DLY-1]) begin
         cap_sel = min_rpm_ff;
      end else if (geslow_ff[DLY-1]) begin
         cap_sel = MaxRpm;
      end else begin
         cap_sel = div_cap;
      end

      rsp_in = '0;
      unique case (mode_ff[DLY-1])
         MODE_NONE: begin
            rsp_in.bound_action = ACT_KEEP;
         end
         MODE_FULL: begin
            rsp_in.bound_action    = ACT_FULL;
            rsp_in.upper_bound_rpm = MaxRpm;
         end
         MODE_DEAD: begin
            rsp_in.bound_action    = ACT_CAP;
            rsp_in.upper_bound_rpm = min_rpm_ff;
         end
         MODE_NORMAL: begin
            rsp_in.bound_action    = ACT_CAP;
            rsp_in.upper_bound_rpm = cap_sel;
            rsp_in.target_update   = 1'b1;
            rsp_in.new_target      = tgt_new;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= mv_ff[DLY-1];
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Every accepted command produces its result after the fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##RSP_LAT rsp_strobe)
      else $error("result strobe missing after an accepted command");

   // The side pipelines stay in step with the decision delay line.
   a_align: assert property (@(posedge clock) disable iff (reset)
      (tgt_v == mv_ff[DLY-1]) && (div_v == mv_ff[DLY-1]))
      else $error("datapath pipelines out of step with the decision");

   // A target update only comes with a speed cap.
   a_update_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.target_update |-> rsp_data.bound_action == ACT_CAP)
      else $error("target update without a speed cap");

   // Keeping the bound carries neither a speed nor a target.
   a_keep_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.bound_action == ACT_KEEP |->
         rsp_data.upper_bound_rpm == '0 && !rsp_data.target_update)
      else $error("keep action carries a bound or a target");

endmodule
